@@ src/bpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bpe_pkg
// Types, constants and scoring helpers for the branch predictor evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

   localparam int INDEX_BITS  = 10;
   localparam int TABLE_DEPTH = 1 << INDEX_BITS;

   localparam int FIFO_DEPTH = 3;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] CLS_OTHER  = 2'd0;
   localparam logic [1:0] CLS_BRANCH = 2'd1;
   localparam logic [1:0] CLS_JUMP   = 2'd2;

   localparam logic [1:0] TWO_BIT_MAX   = 2'd3;
   localparam logic [1:0] TWO_BIT_MIN   = 2'd0;
   localparam logic [1:0] TWO_BIT_RESET = 2'd1;

   typedef logic [INDEX_BITS-1:0] index_type;

   typedef struct packed {
      logic       one_bit;
      logic [1:0] two_bit;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{one_bit: 1'b0, two_bit: TWO_BIT_RESET};

   typedef struct packed {
      entry_type entry;
      logic      one_hit;
      logic      two_hit;
   } score_type;

   typedef struct packed {
      logic        resolved;
      logic        resolved_taken;
      logic [31:0] branch_total;
      logic [31:0] always_taken_hits;
      logic [31:0] always_not_taken_hits;
      logic [31:0] one_bit_hits;
      logic [31:0] two_bit_hits;
   } rsp_type;

   function automatic index_type index_of(logic [31:0] addr);
      return addr[INDEX_BITS+1:2];
   endfunction

   function automatic score_type score_entry(entry_type e, logic taken);
      score_type s;
      s.two_hit = (e.two_bit[1] == taken);
      s.one_hit = (e.one_bit == taken);
      s.entry.one_bit = taken;
      if (taken) begin
         s.entry.two_bit = (e.two_bit == TWO_BIT_MAX) ? TWO_BIT_MAX : e.two_bit + 2'd1;
      end else begin
         s.entry.two_bit = (e.two_bit == TWO_BIT_MIN) ? TWO_BIT_MIN : e.two_bit - 2'd1;
      end
      return s;
   endfunction

   function automatic logic [31:0] sat_add(logic [31:0] v, logic [1:0] n);
      logic [32:0] sum;
      sum = {1'b0, v} + {31'b0, n};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

@@ src/bpe_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// bpe_rsp_fifo
// Small result queue between the scoring stage and the result channel.
// ----------------------------------------------------------------------------
module bpe_rsp_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push_valid,
   input  bpe_pkg::rsp_type                 push_data,
   output logic                             pop_valid,
   input  logic                             pop_stall,
   output bpe_pkg::rsp_type                 pop_data,
   output logic [bpe_pkg::CNT_BITS-1:0]     count
);

   bpe_pkg::rsp_type                 slot_ff [bpe_pkg::FIFO_DEPTH];
   logic [bpe_pkg::PTR_BITS-1:0]     head_ff, head_in;
   logic [bpe_pkg::PTR_BITS-1:0]     tail_ff, tail_in;
   logic [bpe_pkg::CNT_BITS-1:0]     count_ff, count_in;
   logic                             pop;

   function automatic logic [bpe_pkg::PTR_BITS-1:0] ptr_next(
         logic [bpe_pkg::PTR_BITS-1:0] p);
      return (p == bpe_pkg::PTR_BITS'(bpe_pkg::FIFO_DEPTH - 1)) ? '0
                                                                : p + bpe_pkg::PTR_BITS'(1);
   endfunction

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && !pop_stall;
   assign pop_data  = slot_ff[head_ff];
   assign count     = count_ff;

   always_comb begin
      head_in  = pop ? ptr_next(head_ff) : head_ff;
      tail_in  = push_valid ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff + bpe_pkg::CNT_BITS'(push_valid) - bpe_pkg::CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

@@ src/branch_predictor_evaluator.sv @@
// ----------------------------------------------------------------------------
// branch_predictor_evaluator
// Bimodal 1-bit / 2-bit predictor scoring over a stream of executed
// instructions, with one shared table memory and running hit counters.
// ----------------------------------------------------------------------------
// Path: a request beat taken is registered into the scoring stage, then
// pushed into the result queue, from which it leaves as a result beat.
// Throughput: one request per cycle while req_stall is low, set by the single
// read and single write port of the table memory; a one-entry write buffer
// absorbs the second table update when a jump resolves a pending branch.
// Reset: a clearing pass rewrites all TABLE_DEPTH (1024) table entries, one
// index after another; req_stall is held high until it ends.
// ----------------------------------------------------------------------------
module branch_predictor_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pc,
   input  logic [1:0]  req_instr_class,
   input  logic signed [31:0] req_target_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_resolved,
   output logic        rsp_resolved_taken,
   output logic [31:0] rsp_branch_total,
   output logic [31:0] rsp_always_taken_hits,
   output logic [31:0] rsp_always_not_taken_hits,
   output logic [31:0] rsp_one_bit_hits,
   output logic [31:0] rsp_two_bit_hits
);

   typedef struct packed {
      logic                valid;
      bpe_pkg::index_type  addr;
      bpe_pkg::entry_type  data;
   } write_type;

   // table memory
   bpe_pkg::entry_type   table_mem [bpe_pkg::TABLE_DEPTH];
   bpe_pkg::entry_type   rd_ff;
   write_type            port_wr;

   // clearing pass
   logic                 clr_active_ff, clr_active_in;
   bpe_pkg::index_type   clr_idx_ff, clr_idx_in;

   // scoring stage
   logic                 s1_valid_ff;
   logic [31:0]          s1_pc_ff;
   logic [1:0]           s1_cls_ff;
   logic [31:0]          s1_off_ff;

   // pending branch
   logic                 pend_valid_ff, pend_valid_in;
   bpe_pkg::index_type   pend_idx_ff, pend_idx_in;
   logic [31:0]          pend_target_ff, pend_target_in;
   bpe_pkg::entry_type   pend_val_ff, pend_val_in;

   // write buffer and last port write
   write_type            wb_ff, wb_in;
   write_type            lw_ff;

   // counters
   logic [31:0]          total_ff, total_in;
   logic [31:0]          taken_ff, taken_in;
   logic [31:0]          not_taken_ff, not_taken_in;
   logic [31:0]          one_ff, one_in;
   logic [31:0]          two_ff, two_in;

   logic                          req_accept;
   logic [bpe_pkg::CNT_BITS-1:0]  fifo_count;
   bpe_pkg::rsp_type              push_data;
   bpe_pkg::rsp_type              pop_data;

   bpe_pkg::index_type   s1_idx;
   bpe_pkg::entry_type   fwd_val;
   bpe_pkg::entry_type   cur_j;
   bpe_pkg::score_type   sc_p;
   bpe_pkg::score_type   sc_j;
   logic                 resolving;
   logic                 taken_p;
   logic                 is_jump;
   logic                 is_branch;
   write_type            w1;
   write_type            w2;
   logic [1:0]           n_taken, n_not_taken, n_one, n_two;

   assign req_stall  = clr_active_ff ||
                       (({1'b0, fifo_count} + {{bpe_pkg::CNT_BITS{1'b0}}, s1_valid_ff})
                        >= (bpe_pkg::CNT_BITS+1)'(bpe_pkg::FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff     <= table_mem[bpe_pkg::index_of(req_pc)];
         s1_pc_ff  <= req_pc;
         s1_cls_ff <= req_instr_class;
         s1_off_ff <= req_target_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (port_wr.valid) begin
         table_mem[port_wr.addr] <= port_wr.data;
      end
   end

   always_comb begin
      s1_idx    = bpe_pkg::index_of(s1_pc_ff);
      is_jump   = s1_valid_ff && (s1_cls_ff == bpe_pkg::CLS_JUMP);
      is_branch = s1_valid_ff && (s1_cls_ff == bpe_pkg::CLS_BRANCH);
      resolving = s1_valid_ff && pend_valid_ff;
      taken_p   = (s1_pc_ff == pend_target_ff);

      // newest copy of the item's own entry
      if (wb_ff.valid && wb_ff.addr == s1_idx) begin
         fwd_val = wb_ff.data;
      end else if (lw_ff.valid && lw_ff.addr == s1_idx) begin
         fwd_val = lw_ff.data;
      end else begin
         fwd_val = rd_ff;
      end

      sc_p  = bpe_pkg::score_entry(pend_val_ff, taken_p);
      cur_j = (resolving && pend_idx_ff == s1_idx) ? sc_p.entry : fwd_val;
      sc_j  = bpe_pkg::score_entry(cur_j, 1'b1);

      w1.valid = resolving && !(is_jump && pend_idx_ff == s1_idx);
      w1.addr  = pend_idx_ff;
      w1.data  = sc_p.entry;
      w2.valid = is_jump;
      w2.addr  = s1_idx;
      w2.data  = sc_j.entry;
      if (resolving && !w1.valid) begin
         w2.valid = 1'b1;
      end

      port_wr = '0;
      wb_in   = '0;
      if (clr_active_ff) begin
         port_wr.valid = 1'b1;
         port_wr.addr  = clr_idx_ff;
         port_wr.data  = bpe_pkg::ENTRY_RESET;
      end else if (wb_ff.valid) begin
         port_wr = wb_ff;
         if (w1.valid) begin
            wb_in = w1;
         end else if (w2.valid) begin
            wb_in = w2;
         end
      end else if (w1.valid) begin
         port_wr = w1;
         if (w2.valid) begin
            wb_in = w2;
         end
      end else begin
         port_wr = w2;
      end

      clr_active_in = clr_active_ff && (clr_idx_ff != '1);
      clr_idx_in    = clr_active_ff ? clr_idx_ff + bpe_pkg::index_type'(1) : clr_idx_ff;

      pend_valid_in  = s1_valid_ff ? is_branch : pend_valid_ff;
      pend_idx_in    = is_branch ? s1_idx : pend_idx_ff;
      pend_target_in = is_branch ? s1_pc_ff + s1_off_ff : pend_target_ff;
      pend_val_in    = is_branch ? cur_j : pend_val_ff;

      n_taken     = {1'b0, resolving && taken_p} + {1'b0, is_jump};
      n_not_taken = {1'b0, resolving && !taken_p};
      n_one       = {1'b0, resolving && sc_p.one_hit} + {1'b0, is_jump && sc_j.one_hit};
      n_two       = {1'b0, resolving && sc_p.two_hit} + {1'b0, is_jump && sc_j.two_hit};

      total_in     = bpe_pkg::sat_add(total_ff, {1'b0, is_jump || is_branch});
      taken_in     = bpe_pkg::sat_add(taken_ff, n_taken);
      not_taken_in = bpe_pkg::sat_add(not_taken_ff, n_not_taken);
      one_in       = bpe_pkg::sat_add(one_ff, n_one);
      two_in       = bpe_pkg::sat_add(two_ff, n_two);

      push_data.resolved              = resolving || is_jump;
      push_data.resolved_taken        = resolving ? taken_p : is_jump;
      push_data.branch_total          = total_in;
      push_data.always_taken_hits     = taken_in;
      push_data.always_not_taken_hits = not_taken_in;
      push_data.one_bit_hits          = one_in;
      push_data.two_bit_hits          = two_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         wb_ff         <= '0;
         lw_ff         <= '0;
         total_ff      <= '0;
         taken_ff      <= '0;
         not_taken_ff  <= '0;
         one_ff        <= '0;
         two_ff        <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
         s1_valid_ff   <= req_accept;
         pend_valid_ff <= pend_valid_in;
         wb_ff         <= wb_in;
         lw_ff         <= port_wr;
         total_ff      <= total_in;
         taken_ff      <= taken_in;
         not_taken_ff  <= not_taken_in;
         one_ff        <= one_in;
         two_ff        <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      pend_target_ff <= pend_target_in;
      pend_val_ff    <= pend_val_in;
   end

   bpe_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_data  (push_data),
      .pop_valid  (rsp_valid),
      .pop_stall  (rsp_stall),
      .pop_data   (pop_data),
      .count      (fifo_count)
   );

   assign rsp_resolved              = pop_data.resolved;
   assign rsp_resolved_taken        = pop_data.resolved_taken;
   assign rsp_branch_total          = pop_data.branch_total;
   assign rsp_always_taken_hits     = pop_data.always_taken_hits;
   assign rsp_always_not_taken_hits = pop_data.always_not_taken_hits;
   assign rsp_one_bit_hits          = pop_data.one_bit_hits;
   assign rsp_two_bit_hits          = pop_data.two_bit_hits;

   // write buffer never has to hold two table updates
   a_wb_room: assert property (@(posedge clock) disable iff (reset)
      !(wb_ff.valid && w1.valid && w2.valid))
      else $error("table write buffer overflow");

   // the scoring stage always finds room in the result queue
   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (fifo_count < bpe_pkg::CNT_BITS'(bpe_pkg::FIFO_DEPTH)))
      else $error("result queue overflow");

   // no request is taken while the table is being cleared
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |=> !s1_valid_ff)
      else $error("request accepted during table clear");

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for branch_predictor_evaluator. A short directed run
// covers the resolution cases: taken, not taken, target wrap, a branch
// followed by a jump or by a spare class, and the two-bit counter pinned at
// its top. Three random runs then follow with branch sites that repeat,
// each with one of four biases, so that both tables train and alias. A
// scoreboard class keeps its own copy of the tables and counters, predicts
// every result beat, and checks each field in order under random idling
// and stalling.
// ----------------------------------------------------------------------------
module tb_top;
   import bpe_pkg::*;

   localparam logic [1:0]  CLS_SPARE = 2'd3;
   localparam int          NUM_SITES = 16;
   localparam int unsigned RUN_LIMIT = 4_000_000;

   class score_checker;
      logic [1:0]  two_bit_tbl [TABLE_DEPTH];
      logic        one_bit_tbl [TABLE_DEPTH];
      logic        pend_valid;
      logic [31:0] pend_pc;
      logic [31:0] pend_target;
      logic [31:0] n_total;
      logic [31:0] n_taken;
      logic [31:0] n_not_taken;
      logic [31:0] n_one_hits;
      logic [31:0] n_two_hits;
      rsp_type     expected_scores [$];
      int          errors;
      int          beats_checked;
      int          instrs_seen;

      function new();
         foreach (two_bit_tbl[i]) begin
            two_bit_tbl[i] = TWO_BIT_RESET;
            one_bit_tbl[i] = 1'b0;
         end
         pend_valid    = 1'b0;
         pend_pc       = '0;
         pend_target   = '0;
         n_total       = '0;
         n_taken       = '0;
         n_not_taken   = '0;
         n_one_hits    = '0;
         n_two_hits    = '0;
         errors        = 0;
         beats_checked = 0;
         instrs_seen   = 0;
      endfunction

      function logic [31:0] bump(logic [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      // score the outcome against both tables, then train the entry
      function void train(logic [31:0] addr, logic taken);
         index_type  idx;
         logic [1:0] ctr;
         idx = addr[INDEX_BITS+1:2];
         ctr = two_bit_tbl[idx];
         if (ctr[1] == taken) n_two_hits = bump(n_two_hits);
         if (one_bit_tbl[idx] == taken) n_one_hits = bump(n_one_hits);
         if (taken) begin
            if (ctr != TWO_BIT_MAX) ctr = ctr + 2'd1;
            n_taken = bump(n_taken);
         end else begin
            if (ctr != TWO_BIT_MIN) ctr = ctr - 2'd1;
            n_not_taken = bump(n_not_taken);
         end
         two_bit_tbl[idx] = ctr;
         one_bit_tbl[idx] = taken;
      endfunction

      function void record_instr(logic [31:0] pc, logic [1:0] cls, logic [31:0] offset);
         rsp_type want;
         want = '0;
         if (pend_valid) begin
            want.resolved_taken = (pc == pend_target);
            want.resolved       = 1'b1;
            train(pend_pc, want.resolved_taken);
         end
         case (cls)
            CLS_BRANCH: begin
               pend_valid  = 1'b1;
               pend_pc     = pc;
               pend_target = pc + offset;
               n_total     = bump(n_total);
            end
            CLS_JUMP: begin
               pend_valid = 1'b0;
               n_total    = bump(n_total);
               train(pc, 1'b1);
               if (!want.resolved) want.resolved_taken = 1'b1;
               want.resolved = 1'b1;
            end
            default: begin
               pend_valid = 1'b0;
            end
         endcase
         want.branch_total          = n_total;
         want.always_taken_hits     = n_taken;
         want.always_not_taken_hits = n_not_taken;
         want.one_bit_hits          = n_one_hits;
         want.two_bit_hits          = n_two_hits;
         expected_scores.push_back(want);
         instrs_seen++;
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         end
      endfunction

      function void check_scores(rsp_type got);
         rsp_type want;
         if (expected_scores.size() == 0) begin
            errors++;
            $display("%0t: result beat expected none got %h", $time, got);
            return;
         end
         want = expected_scores.pop_front();
         compare("resolved", 32'(want.resolved), 32'(got.resolved));
         compare("resolved_taken", 32'(want.resolved_taken), 32'(got.resolved_taken));
         compare("branch_total", want.branch_total, got.branch_total);
         compare("always_taken_hits", want.always_taken_hits, got.always_taken_hits);
         compare("always_not_taken_hits", want.always_not_taken_hits,
                 got.always_not_taken_hits);
         compare("one_bit_hits", want.one_bit_hits, got.one_bit_hits);
         compare("two_bit_hits", want.two_bit_hits, got.two_bit_hits);
         beats_checked++;
      endfunction
   endclass

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [31:0] req_pc            = '0;
   logic [1:0]  req_instr_class   = CLS_OTHER;
   logic [31:0] req_target_offset = '0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic        rsp_resolved;
   logic        rsp_resolved_taken;
   logic [31:0] rsp_branch_total;
   logic [31:0] rsp_always_taken_hits;
   logic [31:0] rsp_always_not_taken_hits;
   logic [31:0] rsp_one_bit_hits;
   logic [31:0] rsp_two_bit_hits;

   score_checker sb;
   rsp_type      seen_scores;
   int           req_idle_pct  = 0;
   int           rsp_stall_pct = 0;
   logic [31:0]  site_pc  [NUM_SITES];
   logic [31:0]  site_off [NUM_SITES];
   int           site_bias [NUM_SITES];
   logic [31:0]  next_pc = '0;
   logic         after_branch = 1'b0;

   branch_predictor_evaluator uut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_pc                    (req_pc),
      .req_instr_class           (req_instr_class),
      .req_target_offset         (req_target_offset),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_resolved              (rsp_resolved),
      .rsp_resolved_taken        (rsp_resolved_taken),
      .rsp_branch_total          (rsp_branch_total),
      .rsp_always_taken_hits     (rsp_always_taken_hits),
      .rsp_always_not_taken_hits (rsp_always_not_taken_hits),
      .rsp_one_bit_hits          (rsp_one_bit_hits),
      .rsp_two_bit_hits          (rsp_two_bit_hits)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.record_instr(req_pc, req_instr_class, req_target_offset);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_scores = {rsp_resolved, rsp_resolved_taken, rsp_branch_total,
                           rsp_always_taken_hits, rsp_always_not_taken_hits,
                           rsp_one_bit_hits, rsp_two_bit_hits};
            sb.check_scores(seen_scores);
         end
      end
   end

   // entered and left at a falling edge
   task automatic drive_item(input logic [31:0] pc, input logic [1:0] cls,
                             input logic [31:0] offset);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_pc            <= pc;
      req_instr_class   <= cls;
      req_target_offset <= offset;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.expected_scores.size() != 0);
   endtask

   task automatic run_random(input int count);
      int          r;
      int          s;
      logic [31:0] pc;
      logic [31:0] offset;
      logic [1:0]  cls;
      repeat (count) begin
         r      = $urandom_range(99);
         s      = $urandom_range(NUM_SITES - 1);
         pc     = next_pc;
         offset = $urandom;
         if (r < 8) begin
            pc      = $urandom;
            cls     = 2'($urandom_range(3));
            next_pc = $urandom_range(1) ? 32'($urandom) : pc + 32'd4;
         end else if (after_branch) begin
            // resolve against the pc that the branch led to
            r = $urandom_range(99);
            if (r < 72) begin
               cls     = CLS_OTHER;
               next_pc = pc + 32'd4;
            end else if (r < 87) begin
               cls     = CLS_JUMP;
               next_pc = pc + offset;
            end else if (r < 95) begin
               cls     = CLS_BRANCH;
               offset  = 32'($urandom_range(0, 63) * 4) - 32'd128;
               next_pc = $urandom_range(1) ? pc + offset : pc + 32'd4;
            end else begin
               cls     = CLS_SPARE;
               next_pc = pc + 32'd4;
            end
         end else if (r < 55) begin
            cls     = CLS_BRANCH;
            pc      = site_pc[s];
            offset  = site_off[s];
            next_pc = ($urandom_range(99) < site_bias[s]) ? pc + offset : pc + 32'd4;
         end else if (r < 65) begin
            cls = CLS_JUMP;
            if ($urandom_range(1)) pc = site_pc[s];
            next_pc = pc + offset;
         end else if (r < 68) begin
            cls     = CLS_SPARE;
            next_pc = pc + 32'd4;
         end else begin
            cls     = CLS_OTHER;
            next_pc = pc + 32'd4;
         end
         after_branch = (cls == CLS_BRANCH);
         drive_item(pc, cls, offset);
      end
   endtask

   initial begin
      sb = new();
      for (int i = 0; i < NUM_SITES; i++) begin
         site_pc[i] = $urandom;
         site_pc[i][INDEX_BITS+1:2] = (i == NUM_SITES - 1) ? '1 : index_type'($urandom_range(11));
         site_off[i] = (i < NUM_SITES / 2) ? 32'($urandom_range(0, 255) * 4) - 32'd512
                                           : 32'($urandom);
         case (i % 4)
            0: site_bias[i] = 95;
            1: site_bias[i] = 5;
            2: site_bias[i] = 60;
            default: site_bias[i] = 85;
         endcase
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      drive_item(32'h0000_0000, CLS_OTHER, 32'h0000_0000);
      drive_item(32'h0000_0100, CLS_BRANCH, 32'd8);
      drive_item(32'h0000_0108, CLS_OTHER, 32'h7FFF_FFFF);
      drive_item(32'h0000_0100, CLS_BRANCH, 32'd8);
      drive_item(32'h0000_0104, CLS_OTHER, 32'h8000_0000);
      repeat (2) begin
         drive_item(32'h0000_0600, CLS_BRANCH, 32'h20);
         drive_item(32'h0000_0620, CLS_OTHER, 32'h0);
      end
      // target wraps past the top of the address space
      drive_item(32'hFFFF_FFFC, CLS_BRANCH, 32'd8);
      drive_item(32'h0000_0004, CLS_OTHER, 32'h0);
      // pending branch resolved by a jump, taken then not taken
      drive_item(32'h0000_0000, CLS_BRANCH, 32'h8000_0000);
      drive_item(32'h8000_0000, CLS_JUMP, 32'h7FFF_FFFF);
      drive_item(32'h0000_0200, CLS_BRANCH, 32'd16);
      drive_item(32'h0000_0204, CLS_JUMP, 32'hFFFF_FFFF);
      drive_item(32'h0000_0400, CLS_JUMP, 32'h0);
      // spare class resolves and then clears
      drive_item(32'h0000_0300, CLS_BRANCH, 32'd4);
      drive_item(32'h0000_0304, CLS_SPARE, 32'hFFFF_FFFF);
      drive_item(32'h0000_0300, CLS_BRANCH, 32'd4);
      drive_item(32'h0000_0010, CLS_SPARE, 32'h0);
      drive_item(32'h0000_0000, CLS_OTHER, 32'h0);
      drive_item(32'h0000_0500, CLS_BRANCH, 32'd12);
      drive_item(32'h0000_050C, CLS_BRANCH, 32'hFFFF_FFF4);
      drive_item(32'h0000_0500, CLS_JUMP, 32'h0);
      drive_item(32'hFFFF_FFFF, CLS_OTHER, 32'hFFFF_FFFF);
      drive_item(32'h0000_1000, CLS_BRANCH, 32'd4);
      drive_item(32'h0000_1004, CLS_OTHER, 32'h0);

      req_idle_pct  = 8;
      rsp_stall_pct = 61;
      run_random(620);
      hold_until_drained();
      req_idle_pct  = 61;
      rsp_stall_pct = 8;
      run_random(620);
      hold_until_drained();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      run_random(610);

      req_valid <= 1'b0;
      while (sb.expected_scores.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      $display("tb_top: %0d instructions sent, %0d result beats checked",
               sb.instrs_seen, sb.beats_checked);
      $display("tb_top: %0d branches/jumps, %0d taken, %0d not taken, %0d/%0d 1-/2-bit hits",
               sb.n_total, sb.n_taken, sb.n_not_taken, sb.n_one_hits, sb.n_two_hits);
      if (sb.errors == 0 && sb.expected_scores.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
